/* design/spbc_pkg.sv */
// Shared types and constants for the soft power button controller.
// No dependencies; imported by the top level and its checker.
package spbc_pkg;

  localparam int CntW = 16;
  localparam int CfgIdxW = 2;

  typedef enum logic [2:0] {
    PH_WAIT_ON   = 3'd0,
    PH_WAIT_REL  = 3'd1,
    PH_NOTIFY    = 3'd2,
    PH_QUIET     = 3'd3,
    PH_SHUTDOWN  = 3'd4,
    PH_HALTED    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    LED_OFF            = 3'd0,
    LED_ON             = 3'd1,
    LED_BLINK_1000_500 = 3'd2,
    LED_BLINK_5000_50  = 3'd3,
    LED_BLINK_200_100  = 3'd4
  } board_mode_t;

  typedef enum logic [1:0] {
    EXT_OFF    = 2'd0,
    EXT_ON     = 2'd1,
    EXT_FOLLOW = 2'd2
  } ext_mode_t;

  localparam logic [CfgIdxW-1:0] CFG_ON_DELAY      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_DELAY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFF_DELAY     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_NOTIFY        = 2'd3;

  localparam logic [CntW-1:0] ON_DELAY_RESET      = 16'd2000;
  localparam logic [CntW-1:0] RELEASE_DELAY_RESET = 16'd1000;
  localparam logic [CntW-1:0] OFF_DELAY_RESET     = 16'd2000;
  localparam logic [CntW-1:0] NOTIFY_RESET        = 16'd5000;

  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

endpackage

/* design/soft_power_button_controller.sv */
// Soft power latch: long press on, long press off, notify and quiet phases.
// The result beat of an accepted tick beat is registered and follows in the next cycle.
// Throughput: one tick beat per cycle while out_ready is high; the result register frees as it drains.
// Reset (rst, synchronous): phase wait-on, counters and hold cleared,
// delay registers back to 2000/1000/2000/5000 ms, no result pending.
// Depends on spbc_pkg.
module soft_power_button_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          button_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hold_out,
  output logic [2:0]                    board_led_mode,
  output logic [1:0]                    ext_led_mode,
  output logic                          off_request,
  output logic [2:0]                    phase,
  input  logic                          cfg_we,
  input  logic [spbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [spbc_pkg::CntW-1:0]     cfg_data
);
  import spbc_pkg::*;

  logic [CntW-1:0] on_delay_ms;
  logic [CntW-1:0] release_delay_ms;
  logic [CntW-1:0] off_delay_ms;
  logic [CntW-1:0] notify_ms;

  phase_t          phase_reg, phase_next;
  logic [CntW-1:0] qualify_count, qualify_count_next;
  logic [CntW-1:0] notify_count, notify_count_next;
  logic            hold_reg, hold_next;
  logic            off_req_next;
  board_mode_t     board_next;
  ext_mode_t       ext_next;
  logic [2:0]      phase_out_next;
  logic            accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_delay_ms      <= ON_DELAY_RESET;
      release_delay_ms <= RELEASE_DELAY_RESET;
      off_delay_ms     <= OFF_DELAY_RESET;
      notify_ms        <= NOTIFY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_DELAY:      on_delay_ms      <= cfg_data;
        CFG_RELEASE_DELAY: release_delay_ms <= cfg_data;
        CFG_OFF_DELAY:     off_delay_ms     <= cfg_data;
        CFG_NOTIFY:        notify_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state for one tick.
  always_comb begin
    phase_next         = phase_reg;
    qualify_count_next = qualify_count;
    notify_count_next  = notify_count;
    hold_next          = hold_reg;
    off_req_next       = 1'b0;
    case (phase_reg)
      PH_WAIT_ON: begin
        if (button_level == LEVEL_PRESSED) begin
          if (qualify_count >= on_delay_ms) begin
            hold_next          = 1'b1;
            phase_next         = PH_WAIT_REL;
            qualify_count_next = '0;
          end else begin
            qualify_count_next = qualify_count + 1'b1;
          end
        end else begin
          qualify_count_next = '0;
        end
      end
      PH_WAIT_REL: begin
        if (button_level == LEVEL_RELEASED) begin
          if (qualify_count >= release_delay_ms) begin
            phase_next         = PH_NOTIFY;
            notify_count_next  = '0;
            qualify_count_next = '0;
          end else begin
            qualify_count_next = qualify_count + 1'b1;
          end
        end else begin
          qualify_count_next = '0;
        end
      end
      PH_NOTIFY, PH_QUIET: begin
        if (phase_reg == PH_NOTIFY) begin
          if (notify_count >= notify_ms) begin
            phase_next = PH_QUIET;
          end else begin
            notify_count_next = notify_count + 1'b1;
          end
        end else if (button_level == LEVEL_PRESSED) begin
          // any press during quiet restarts notify
          phase_next        = PH_NOTIFY;
          notify_count_next = '0;
        end
        if (button_level == LEVEL_PRESSED) begin
          if (qualify_count >= off_delay_ms) begin
            off_req_next       = 1'b1;
            hold_next          = 1'b0;
            phase_next         = PH_SHUTDOWN;
            qualify_count_next = '0;
          end else begin
            qualify_count_next = qualify_count + 1'b1;
          end
        end else begin
          qualify_count_next = '0;
        end
      end
      PH_SHUTDOWN: begin
        if (button_level == LEVEL_RELEASED) begin
          phase_next = PH_HALTED;
        end
      end
      default: ;
    endcase
  end

  // Output decode from the phase after the tick.
  always_comb begin
    case (phase_next)
      PH_WAIT_ON: begin
        board_next     = LED_OFF;
        ext_next       = EXT_OFF;
        phase_out_next = PH_WAIT_ON;
      end
      PH_WAIT_REL: begin
        board_next     = LED_ON;
        ext_next       = EXT_ON;
        phase_out_next = PH_WAIT_REL;
      end
      PH_NOTIFY: begin
        board_next     = LED_BLINK_1000_500;
        ext_next       = EXT_FOLLOW;
        phase_out_next = PH_NOTIFY;
      end
      PH_QUIET: begin
        board_next     = LED_BLINK_5000_50;
        ext_next       = EXT_OFF;
        phase_out_next = PH_QUIET;
      end
      PH_SHUTDOWN: begin
        board_next     = LED_BLINK_200_100;
        ext_next       = EXT_FOLLOW;
        phase_out_next = PH_SHUTDOWN;
      end
      default: begin
        board_next     = LED_ON;
        ext_next       = EXT_OFF;
        phase_out_next = PH_HALTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_WAIT_ON;
      qualify_count <= '0;
      notify_count  <= '0;
      hold_reg      <= 1'b0;
    end else if (accept) begin
      phase_reg     <= phase_next;
      qualify_count <= qualify_count_next;
      notify_count  <= notify_count_next;
      hold_reg      <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_out       <= hold_next;
      board_led_mode <= board_next;
      ext_led_mode   <= ext_next;
      off_request    <= off_req_next;
      phase          <= phase_out_next;
    end
  end

endmodule

/* design/spbc_checker.sv */
// Port-level checker for soft_power_button_controller, bound to the top level.
// Depends on spbc_pkg.
module spbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hold_out,
  input logic [2:0] board_led_mode,
  input logic [1:0] ext_led_mode,
  input logic       off_request,
  input logic [2:0] phase
);
  import spbc_pkg::*;

  // hold is never set before power-on qualifies
  a_off_no_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_WAIT_ON |-> !hold_out)
    else $error("hold asserted while waiting for power on");

  // powered phases keep hold high
  a_on_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == PH_WAIT_REL || phase == PH_NOTIFY || phase == PH_QUIET)
    |-> hold_out)
    else $error("hold dropped while powered");

  // an off request lands in shutdown with hold released
  a_off_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && off_request |-> phase == PH_SHUTDOWN && !hold_out)
    else $error("off request without shutdown");

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(hold_out)
      && $stable(board_led_mode) && $stable(ext_led_mode) && $stable(off_request))
    else $error("result beat changed while stalled");

endmodule

bind soft_power_button_controller spbc_checker u_spbc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .hold_out       (hold_out),
  .board_led_mode (board_led_mode),
  .ext_led_mode   (ext_led_mode),
  .off_request    (off_request),
  .phase          (phase)
);
